### rtl/core/backend_load_balancer_select_assert.svh
`ifndef BACKEND_LOAD_BALANCER_SELECT_ASSERT_SVH
`define BACKEND_LOAD_BALANCER_SELECT_ASSERT_SVH

// Checks that a condition implies a consequence in the same cycle, outside reset.
`define BLBS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks that a condition implies a consequence in the next cycle, outside reset.
`define BLBS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/blbs_pkg.sv
package blbs_pkg;

   // Table size limits and field widths.
   localparam int DEFAULT_MAX_SERVERS = 8;
   localparam int SLOT_LIMIT          = 8;
   localparam int IDX_W               = 3;
   localparam int CNT_W               = 4;
   localparam int STEP_W              = 4;
   localparam int FUNC_W              = 3;
   localparam int IP_W                = 32;
   localparam int OPEN_W              = 16;
   localparam int MODE_W              = 2;
   localparam int MASK_W              = 8;
   localparam int TALLY_W             = 2;
   localparam int CSR_ADDR_W          = 1;
   localparam int CSR_DATA_W          = 8;
   localparam int REQ_DATA_W          = 40;
   localparam int RSP_DATA_W          = 8;
   localparam int RSP_USER_W          = 1;

   // Sequencing lengths: four character phases per octet, one nibble per modulo step.
   localparam int HASH_STEPS = 16;
   localparam int MOD_NIBBLE = 4;
   localparam int MOD_STEPS  = IP_W / MOD_NIBBLE;

   // Hash and failure constants.
   localparam logic [IP_W-1:0] HASH_MULT  = 32'd31;
   localparam int              FAIL_LIMIT = 3;
   localparam logic [7:0]      CHAR_ZERO  = 8'h30;
   localparam logic [7:0]      CHAR_DOT   = 8'h2E;
   localparam logic [7:0]      OCT_HUND   = 8'd100;
   localparam logic [7:0]      OCT_TEN    = 8'd10;

   // Request kinds.
   typedef logic [FUNC_W-1:0] func_type;
   localparam func_type FUNC_SELECT  = 3'd0;
   localparam func_type FUNC_OPEN    = 3'd1;
   localparam func_type FUNC_CLOSE   = 3'd2;
   localparam func_type FUNC_SUCCESS = 3'd3;
   localparam func_type FUNC_FAILURE = 3'd4;

   // Selection modes.
   typedef logic [MODE_W-1:0] mode_type;
   localparam mode_type MODE_ROUND_ROBIN = 2'd0;
   localparam mode_type MODE_LEAST_CONN  = 2'd1;
   localparam mode_type MODE_IP_HASH     = 2'd2;
   localparam mode_type MODE_FIRST       = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_SELECT_MODE  = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PRESENT_MASK = 1'd1;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ELIG,
      ST_HASH,
      ST_MOD,
      ST_SCAN,
      ST_LEAST,
      ST_UPDATE,
      ST_DONE
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic elig_load;
      logic turn_load;
      logic hash_step;
      logic mod_step;
      logic scan_step;
      logic least_step;
      logic step_clear;
      logic update;
      logic rsp_load;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic     req_select;
      mode_type mode;
      logic     count_zero;
      logic     step_last_hash;
      logic     step_last_mod;
      logic     step_last_scan;
      logic     scan_hit;
      logic     rsp_free;
   } dp_status_type;

   // Decimal digits of one address octet.
   typedef struct packed {
      logic [3:0] hund;
      logic [3:0] tens;
      logic [3:0] ones;
   } dec_digits_type;

   // Splits an octet into decimal digits; tens use a reciprocal multiply valid below 100.
   function automatic dec_digits_type dec_digits(input logic [7:0] oct);
      logic [7:0]     rest;
      logic [13:0]    prod;
      dec_digits_type d;
      if (oct >= 8'd200) begin
         d.hund = 4'd2;
         rest   = oct - 8'd200;
      end else if (oct >= OCT_HUND) begin
         d.hund = 4'd1;
         rest   = oct - OCT_HUND;
      end else begin
         d.hund = 4'd0;
         rest   = oct;
      end
      prod   = 14'(rest) * 14'd103;
      d.tens = prod[13:10];
      d.ones = 4'(rest - 8'(d.tens) * OCT_TEN);
      return d;
   endfunction

endpackage

### rtl/core/blbs_ctrl.sv
module blbs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output blbs_pkg::dp_cmd_type    cmd,
   input  blbs_pkg::dp_status_type status
);

   blbs_pkg::ctrl_state_type state_ff;
   blbs_pkg::ctrl_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= blbs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = (state_ff == blbs_pkg::ST_IDLE);
      case (state_ff)
         blbs_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = status.req_select ? blbs_pkg::ST_ELIG : blbs_pkg::ST_UPDATE;
            end
         end
         blbs_pkg::ST_ELIG: begin
            cmd.elig_load  = 1'b1;
            cmd.step_clear = 1'b1;
            if (status.count_zero) begin
               state_in = blbs_pkg::ST_DONE;
            end else begin
               case (status.mode)
                  blbs_pkg::MODE_ROUND_ROBIN: begin
                     cmd.turn_load = 1'b1;
                     state_in      = blbs_pkg::ST_MOD;
                  end
                  blbs_pkg::MODE_LEAST_CONN: state_in = blbs_pkg::ST_LEAST;
                  blbs_pkg::MODE_IP_HASH:    state_in = blbs_pkg::ST_HASH;
                  default:                   state_in = blbs_pkg::ST_SCAN;
               endcase
            end
         end
         blbs_pkg::ST_HASH: begin
            cmd.hash_step = 1'b1;
            if (status.step_last_hash) begin
               state_in = blbs_pkg::ST_MOD;
            end
         end
         blbs_pkg::ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (status.step_last_mod) begin
               cmd.step_clear = 1'b1;
               state_in       = blbs_pkg::ST_SCAN;
            end
         end
         blbs_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_hit || status.step_last_scan) begin
               state_in = blbs_pkg::ST_DONE;
            end
         end
         blbs_pkg::ST_LEAST: begin
            cmd.least_step = 1'b1;
            if (status.step_last_scan) begin
               state_in = blbs_pkg::ST_DONE;
            end
         end
         blbs_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = blbs_pkg::ST_DONE;
         end
         blbs_pkg::ST_DONE: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = blbs_pkg::ST_IDLE;
            end
         end
         default: state_in = blbs_pkg::ST_IDLE;
      endcase
   end

endmodule

### rtl/core/blbs_datapath.sv
module blbs_datapath #(
   parameter int MAX_SERVERS = blbs_pkg::DEFAULT_MAX_SERVERS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [blbs_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [blbs_pkg::FUNC_W-1:0]         req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [blbs_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [blbs_pkg::RSP_USER_W-1:0]     rsp_tuser,
   input  logic                                csr_we,
   input  logic [blbs_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [blbs_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  blbs_pkg::dp_cmd_type                cmd,
   output blbs_pkg::dp_status_type             status
);

   // Slots at or above the mask width can never be present.
   localparam int NUM_SLOTS = (MAX_SERVERS < blbs_pkg::SLOT_LIMIT) ?
                              MAX_SERVERS : blbs_pkg::SLOT_LIMIT;
   localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int IDX_W     = blbs_pkg::IDX_W;
   localparam int CNT_W     = blbs_pkg::CNT_W;
   localparam int STEP_W    = blbs_pkg::STEP_W;
   localparam int IP_W      = blbs_pkg::IP_W;
   localparam int OPEN_W    = blbs_pkg::OPEN_W;
   localparam int NIB       = blbs_pkg::MOD_NIBBLE;

   // Character phases within one octet of the address text.
   localparam logic [1:0] PH_HUND = 2'd0;
   localparam logic [1:0] PH_TENS = 2'd1;
   localparam logic [1:0] PH_ONES = 2'd2;
   localparam logic [1:0] LAST_OCTET = 2'd3;

   // Configuration and request registers.
   blbs_pkg::mode_type               mode_ff;
   logic [blbs_pkg::MASK_W-1:0]      mask_ff;
   blbs_pkg::func_type               func_ff;
   logic [IP_W-1:0]                  ip_ff;
   logic [IDX_W-1:0]                 idx_ff;

   // Table state.
   logic [NUM_SLOTS-1:0]             active_ff, active_in;
   logic [OPEN_W-1:0]                open_ff [NUM_SLOTS];
   logic                             open_wr;
   logic [OPEN_W-1:0]                open_wdata;
   logic [IP_W-1:0]                  turn_ff, turn_in;
   logic [blbs_pkg::TALLY_W-1:0]     tally_ff, tally_in;

   // Selection working registers.
   logic [NUM_SLOTS-1:0]             elig_ff, elig_in;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic [IP_W-1:0]                  dividend_ff, dividend_in;
   logic [IDX_W-1:0]                 rem_ff, rem_in;
   logic [STEP_W-1:0]                step_ff, step_in;
   logic [IDX_W-1:0]                 seen_ff, seen_in;
   logic [IDX_W-1:0]                 pick_ff, pick_in;
   logic [OPEN_W-1:0]                least_ff, least_in;
   logic                             best_ff, best_in;

   // Output register.
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_found_ff;
   logic [IDX_W-1:0]                 rsp_index_ff;
   logic                             rsp_active_ff;

   logic                             ok;
   logic [SLOT_W-1:0]                idx_slot;
   logic [SLOT_W-1:0]                step_slot;
   logic [SLOT_W-1:0]                rd_slot;
   logic [OPEN_W-1:0]                rd_count;
   logic                             addr_active;
   logic                             step_elig;
   logic                             found;
   logic [1:0]                       octet_sel;
   logic [1:0]                       phase;
   logic [7:0]                       oct;
   blbs_pkg::dec_digits_type         digits;
   logic                             ch_apply;
   logic [7:0]                       ch;
   logic [IP_W-1:0]                  hash_next;
   logic [IDX_W-1:0]                 mod_rem;

   assign ok          = {1'b0, idx_ff} < (IDX_W + 1)'(NUM_SLOTS);
   assign idx_slot    = idx_ff[SLOT_W-1:0];
   assign step_slot   = step_ff[SLOT_W-1:0];
   assign rd_slot     = cmd.least_step ? step_slot : idx_slot;
   assign rd_count    = open_ff[rd_slot];
   assign addr_active = ok ? active_ff[idx_slot] : 1'b0;
   assign step_elig   = elig_ff[step_slot];
   assign found       = (func_ff == blbs_pkg::FUNC_SELECT) && (count_ff != '0);

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= blbs_pkg::MODE_ROUND_ROBIN;
         mask_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            blbs_pkg::CSR_SELECT_MODE:  mode_ff <= csr_wdata[blbs_pkg::MODE_W-1:0];
            blbs_pkg::CSR_PRESENT_MASK: mask_ff <= csr_wdata[blbs_pkg::MASK_W-1:0];
            default: ;
         endcase
      end
   end

   // Request capture; the fields are payload and need no reset.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_tuser;
         ip_ff   <= req_tdata[IP_W-1:0];
         idx_ff  <= req_tdata[IP_W +: IDX_W];
      end
   end

   // Eligible slots and their population count.
   always_comb begin
      elig_in  = '0;
      count_in = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         elig_in[i] = mask_ff[i] & active_ff[i];
         count_in   = count_in + CNT_W'(elig_in[i]);
      end
   end

   // Connection counts, active flags and the shared failure tally.
   always_comb begin
      active_in  = active_ff;
      tally_in   = tally_ff;
      open_wr    = 1'b0;
      open_wdata = rd_count;
      if (cmd.update && ok) begin
         case (func_ff)
            blbs_pkg::FUNC_OPEN: begin
               if (rd_count != '1) begin
                  open_wr    = 1'b1;
                  open_wdata = rd_count + OPEN_W'(1);
               end
            end
            blbs_pkg::FUNC_CLOSE: begin
               if (rd_count != '0) begin
                  open_wr    = 1'b1;
                  open_wdata = rd_count - OPEN_W'(1);
               end
            end
            blbs_pkg::FUNC_SUCCESS: active_in[idx_slot] = 1'b1;
            blbs_pkg::FUNC_FAILURE: begin
               if ((tally_ff + 2'd1) == blbs_pkg::TALLY_W'(blbs_pkg::FAIL_LIMIT)) begin
                  active_in[idx_slot] = 1'b0;
                  tally_in            = '0;
               end else begin
                  tally_in = tally_ff + 2'd1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '1;
         tally_ff  <= '0;
         turn_ff   <= '0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            open_ff[i] <= '0;
         end
      end else begin
         active_ff <= active_in;
         tally_ff  <= tally_in;
         turn_ff   <= turn_in;
         if (open_wr) begin
            open_ff[idx_slot] <= open_wdata;
         end
      end
   end

   // One character of the dotted-decimal address text per hash step.
   assign octet_sel = step_ff[3:2];
   assign phase     = step_ff[1:0];
   assign oct       = 8'(ip_ff >> {~octet_sel, 3'b000});
   assign digits    = blbs_pkg::dec_digits(oct);

   always_comb begin
      case (phase)
         PH_HUND: begin
            ch_apply = (oct >= blbs_pkg::OCT_HUND);
            ch       = blbs_pkg::CHAR_ZERO + 8'(digits.hund);
         end
         PH_TENS: begin
            ch_apply = (oct >= blbs_pkg::OCT_TEN);
            ch       = blbs_pkg::CHAR_ZERO + 8'(digits.tens);
         end
         PH_ONES: begin
            ch_apply = 1'b1;
            ch       = blbs_pkg::CHAR_ZERO + 8'(digits.ones);
         end
         default: begin
            ch_apply = (octet_sel != LAST_OCTET);
            ch       = blbs_pkg::CHAR_DOT;
         end
      endcase
   end

   assign hash_next = IP_W'(dividend_ff * blbs_pkg::HASH_MULT) + IP_W'(ch);

   // Remainder by the eligible count, one nibble per step, one bit at a time.
   always_comb begin
      logic [IDX_W:0] trial;
      mod_rem = rem_ff;
      for (int b = NIB - 1; b >= 0; b--) begin
         trial = {mod_rem, dividend_ff[IP_W - NIB + b]};
         if (trial >= count_ff) begin
            trial = trial - count_ff;
         end
         mod_rem = trial[IDX_W-1:0];
      end
   end

   // Working register updates for hash, modulo, scan and least search.
   always_comb begin
      turn_in     = turn_ff;
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      seen_in     = seen_ff;
      pick_in     = pick_ff;
      least_in    = least_ff;
      best_in     = best_ff;
      step_in     = step_ff;

      if (cmd.elig_load) begin
         dividend_in = '0;
         rem_in      = '0;
         seen_in     = '0;
         best_in     = 1'b0;
      end
      if (cmd.turn_load) begin
         dividend_in = turn_ff;
         turn_in     = turn_ff + IP_W'(1);
      end
      if (cmd.hash_step && ch_apply) begin
         dividend_in = hash_next;
      end
      if (cmd.mod_step) begin
         dividend_in = dividend_ff << NIB;
         rem_in      = mod_rem;
      end
      if (cmd.scan_step && step_elig) begin
         if (seen_ff == rem_ff) begin
            pick_in = step_ff[IDX_W-1:0];
         end
         seen_in = seen_ff + IDX_W'(1);
      end
      if (cmd.least_step && step_elig && (!best_ff || rd_count < least_ff)) begin
         least_in = rd_count;
         pick_in  = step_ff[IDX_W-1:0];
         best_in  = 1'b1;
      end

      if (cmd.step_clear) begin
         step_in = '0;
      end else if (cmd.hash_step || cmd.mod_step || cmd.scan_step || cmd.least_step) begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         best_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         best_ff <= best_in;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      seen_ff     <= seen_in;
      pick_ff     <= pick_in;
      least_ff    <= least_in;
      if (cmd.elig_load) begin
         elig_ff  <= elig_in;
         count_ff <= count_in;
      end
   end

   // Output register; a finished transaction waits here while the next request enters.
   assign rsp_valid_in = cmd.rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_found_ff  <= found;
         rsp_index_ff  <= found ? pick_ff : '0;
         if (func_ff == blbs_pkg::FUNC_SELECT) begin
            rsp_active_ff <= found;
         end else begin
            rsp_active_ff <= addr_active;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {(blbs_pkg::RSP_DATA_W - IDX_W - 1)'(0), rsp_active_ff, rsp_index_ff};

   // Status back to the controller.
   assign status.req_select     = (req_tuser == blbs_pkg::FUNC_SELECT);
   assign status.mode           = mode_ff;
   assign status.count_zero     = (count_in == '0);
   assign status.step_last_hash = (step_ff == STEP_W'(blbs_pkg::HASH_STEPS - 1));
   assign status.step_last_mod  = (step_ff == STEP_W'(blbs_pkg::MOD_STEPS - 1));
   assign status.step_last_scan = (step_ff == STEP_W'(NUM_SLOTS - 1));
   assign status.scan_hit       = step_elig && (seen_ff == rem_ff);
   assign status.rsp_free       = !rsp_valid_ff || rsp_tready;

endmodule

### rtl/core/backend_load_balancer_select.sv
// Backend selection: a non-select request passes through an update state, then the result state.
// Select goes straight to the result when no slot is eligible; first-active and least-connections
// scan the slots, round robin runs the modulo of the turn counter and then the slot scan, and
// the address hash runs 16 text steps, then 8 nibble steps of the modulo, then the slot scan.
// One request is in work at a time; the next is accepted once the result is registered.
// Reset is synchronous: all slots active, connection counts, turn and failure tally zero.
`include "backend_load_balancer_select_assert.svh"

module backend_load_balancer_select #(
   parameter int MAX_SERVERS = blbs_pkg::DEFAULT_MAX_SERVERS
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Bits from low: address[31:0], server_index[34:32], zero fill[39:35].
   input  logic [blbs_pkg::REQ_DATA_W-1:0]     req_tdata,
   // Bits from low: func[2:0].
   input  logic [blbs_pkg::FUNC_W-1:0]         req_tuser,
   // Result channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Bits from low: chosen_index[2:0], server_now_active[3], zero fill[7:4].
   output logic [blbs_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // Bits from low: found[0].
   output logic [blbs_pkg::RSP_USER_W-1:0]     rsp_tuser,
   // Configuration writes.
   input  logic                                csr_we,
   input  logic [blbs_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [blbs_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   blbs_pkg::dp_cmd_type    cmd;
   blbs_pkg::dp_status_type status;

   // Result fields as seen on the result channel.
   logic                       rsp_found;
   logic                       rsp_active;
   logic [blbs_pkg::IDX_W-1:0] rsp_index;

   // Sequencing of each transaction.
   blbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // Table state, hash, modulo, scan and output register.
   blbs_datapath #(
      .MAX_SERVERS (MAX_SERVERS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status)
   );

   assign rsp_found  = rsp_tuser[0];
   assign rsp_active = rsp_tdata[blbs_pkg::IDX_W];
   assign rsp_index  = rsp_tdata[blbs_pkg::IDX_W-1:0];

   // A new transaction is never taken while one is still in work.
   `BLBS_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "busy accept")
   // A found server is active by definition.
   `BLBS_ASSERT_SAME(a_found_active, rsp_tvalid && rsp_found, rsp_active, "found server inactive")
   // Without a found server the chosen index reads zero.
   `BLBS_ASSERT_SAME(a_index_zero, rsp_tvalid && !rsp_found, rsp_index == '0, "stray index")
   // A new result only appears after a transaction was in work.
   `BLBS_ASSERT_SAME(a_result_from_work, $rose(rsp_tvalid), !$past(req_tready), "idle result")

endmodule
